// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by the project's checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// File: sv/c437u8_pkg.sv
// ----------------------------------------------------------------------------
// c437u8_pkg
// Types and the code page 437 upper-half table for the transcoder.
// ----------------------------------------------------------------------------
package c437u8_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CP_W   = 16;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [CP_W-1:0]   cp_type;

   // encoded character: up to three bytes, lead byte first
   typedef struct packed {
      byte_type   b0;
      byte_type   b1;
      byte_type   b2;
      logic [1:0] nbytes;
   } enc_type;

   localparam logic [1:0] NBYTES_ONE   = 2'd1;
   localparam logic [1:0] NBYTES_TWO   = 2'd2;
   localparam logic [1:0] NBYTES_THREE = 2'd3;

   localparam cp_type CP437_HIGH [128] = '{
      16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
      16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
      16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
      16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
      16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
      16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
      16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
      16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
      16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
      16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
      16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
      16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
      16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
      16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
      16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
      16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
   };

endpackage

// File: sv/c437u8_if.sv
// ----------------------------------------------------------------------------
// c437u8 stream interfaces
// Valid/ready channels for input characters and UTF-8 result bytes.
// ----------------------------------------------------------------------------
interface c437u8_req_if;
   import c437u8_pkg::*;
   logic     valid;
   logic     ready;
   byte_type in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface c437u8_rsp_if;
   import c437u8_pkg::*;
   logic     valid;
   logic     ready;
   byte_type out_byte;
   logic     last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// File: sv/c437u8_lookup.sv
// ----------------------------------------------------------------------------
// c437u8_lookup
// Input register stage and table lookup stage: byte to code point.
// ----------------------------------------------------------------------------
module c437u8_lookup
   import c437u8_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  byte_type in_byte,
   output logic     out_valid,
   input  logic     out_ready,
   output cp_type   out_cp
);

   logic     s1_valid_ff, s1_valid_in;
   byte_type s1_byte_ff;
   logic     s2_valid_ff, s2_valid_in;
   cp_type   s2_cp_ff, s2_cp_in;
   logic     s1_ready, s2_ready;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;

   always_comb begin
      s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
      if (s1_byte_ff[BYTE_W-1]) begin
         s2_cp_in = CP437_HIGH[s1_byte_ff[BYTE_W-2:0]];
      end else begin
         s2_cp_in = {{(CP_W-BYTE_W){1'b0}}, s1_byte_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (s1_ready && in_valid) begin
         s1_byte_ff <= in_byte;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_cp_ff <= s2_cp_in;
      end
   end

   assign in_ready  = s1_ready;
   assign out_valid = s2_valid_ff;
   assign out_cp    = s2_cp_ff;

endmodule

// File: sv/c437u8_encode.sv
// ----------------------------------------------------------------------------
// c437u8_encode
// UTF-8 encode stage: code point to one, two or three bytes.
// ----------------------------------------------------------------------------
module c437u8_encode
   import c437u8_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cp_type  in_cp,
   output logic    out_valid,
   input  logic    out_ready,
   output enc_type out_enc
);

   logic    valid_ff, valid_in;
   enc_type enc_ff, enc_in;
   logic    stage_ready;

   assign stage_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = stage_ready ? in_valid : valid_ff;
      enc_in   = '0;
      if (in_cp[CP_W-1:7] == '0) begin
         enc_in.b0     = in_cp[BYTE_W-1:0];
         enc_in.nbytes = NBYTES_ONE;
      end else if (in_cp[CP_W-1:11] == '0) begin
         enc_in.b0     = {3'b110, in_cp[10:6]};
         enc_in.b1     = {2'b10, in_cp[5:0]};
         enc_in.nbytes = NBYTES_TWO;
      end else begin
         enc_in.b0     = {4'b1110, in_cp[15:12]};
         enc_in.b1     = {2'b10, in_cp[11:6]};
         enc_in.b2     = {2'b10, in_cp[5:0]};
         enc_in.nbytes = NBYTES_THREE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (stage_ready && in_valid) begin
         enc_ff <= enc_in;
      end
   end

   assign in_ready  = stage_ready;
   assign out_valid = valid_ff;
   assign out_enc   = enc_ff;

endmodule

// File: sv/c437u8_serial.sv
// ----------------------------------------------------------------------------
// c437u8_serial
// Output stage: sends the encoded bytes one per cycle while out_ready is high and marks the last.
// ----------------------------------------------------------------------------
module c437u8_serial
   import c437u8_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  enc_type  in_enc,
   output logic     out_valid,
   input  logic     out_ready,
   output byte_type out_byte,
   output logic     out_last
);

   logic       valid_ff, valid_in;
   enc_type    enc_ff;
   logic [1:0] idx_ff, idx_in;
   logic       last;
   logic       fire;
   logic       load;

   assign last     = (idx_ff == (enc_ff.nbytes - 2'd1));
   assign fire     = valid_ff && out_ready;
   assign in_ready = !valid_ff || (fire && last);
   assign load     = in_ready && in_valid;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (fire) begin
         idx_in = idx_ff + 2'd1;
      end
      if (in_ready) begin
         valid_in = in_valid;
         idx_in   = 2'd0;
      end
   end

   always_comb begin
      case (idx_ff)
         2'd0:    out_byte = enc_ff.b0;
         2'd1:    out_byte = enc_ff.b1;
         default: out_byte = enc_ff.b2;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      if (load) begin
         enc_ff <= in_enc;
      end
   end

   assign out_valid = valid_ff;
   assign out_last  = last;

endmodule

// File: sv/cp437_to_utf8_transcoder_core.sv
// ----------------------------------------------------------------------------
// cp437_to_utf8_transcoder_core
// Code page 437 to UTF-8 transcoder: one character byte in, one to three
// UTF-8 bytes out, last byte marked.
//
//   channel  dir  payload               handshake
//   req      in   in_byte[7:0]          valid/ready
//   rsp      out  out_byte[7:0], last   valid/ready
//
// A req byte passes the input, lookup, encode and output registers before
// its first rsp byte. Throughput: one rsp byte per cycle while rsp is not
// stalled; the output stage takes a new character only once the last byte
// of the one before is taken, and bytes below 128 flow at one item per cycle.
// Reset clears all valid bits and the output byte index; no other state.
// A stalled rsp holds its byte; each other stage takes a new item whenever
// the stage after it is empty or moving.
// ----------------------------------------------------------------------------
module cp437_to_utf8_transcoder_core
   import c437u8_pkg::*;
(
   input logic          clock,
   input logic          reset,
   c437u8_req_if.sink   req,
   c437u8_rsp_if.source rsp
);

   logic    lk_valid, lk_ready;
   cp_type  lk_cp;
   logic    en_valid, en_ready;
   enc_type en_enc;

   c437u8_lookup u_lookup (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_byte   (req.in_byte),
      .out_valid (lk_valid),
      .out_ready (lk_ready),
      .out_cp    (lk_cp)
   );

   c437u8_encode u_encode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lk_valid),
      .in_ready  (lk_ready),
      .in_cp     (lk_cp),
      .out_valid (en_valid),
      .out_ready (en_ready),
      .out_enc   (en_enc)
   );

   c437u8_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (en_valid),
      .in_ready  (en_ready),
      .in_enc    (en_enc),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_byte  (rsp.out_byte),
      .out_last  (rsp.last)
   );

endmodule

// File: sv/c437u8_checker.sv
// ----------------------------------------------------------------------------
// c437u8_checker
// Port-level checks on the transcoder's result stream, bound to the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module c437u8_checker
   import c437u8_pkg::*;
(
   input logic     clock,
   input logic     reset,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input byte_type rsp_out_byte,
   input logic     rsp_last
);

   `ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)
   `ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
   `ASSERT_IMPLY(a_nonlast_high, clock, reset, rsp_valid && !rsp_last, rsp_out_byte[7])
   `ASSERT_NEXT(a_cont_follows, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid && (rsp_out_byte[7:6] == 2'b10))

endmodule

bind cp437_to_utf8_transcoder_core c437u8_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_out_byte (rsp.out_byte),
   .rsp_last     (rsp.last)
);

// File: sim/tb_cp437_to_utf8_transcoder_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cp437_to_utf8_transcoder_core
// Self-checking bench for the code page 437 to UTF-8 transcoder. A directed
// table covers the ASCII limits, the ends of the upper half and two-byte and
// three-byte characters. Random characters then run in phases with and
// without gaps on the input and stalls on the output. One long output
// hold-off backs the pipeline up onto its input. Every output byte and its
// last flag are checked against the table or an encoder kept in the bench.
// ----------------------------------------------------------------------------
module tb_cp437_to_utf8_transcoder_core
   import c437u8_pkg::*;
();

   localparam logic [1:0]  FROM_ENCODER   = 2'd0;
   localparam int unsigned RANDOM_CHARS   = 280;
   localparam int unsigned PHASES         = 4;
   localparam int unsigned HOLD_AT_BYTE   = 60;
   localparam int unsigned HOLD_CYCLES    = 100;
   localparam int unsigned DRAIN_CYCLES   = 16;
   localparam int unsigned MAX_PRINTED    = 20;

   // upper half of the code page as Unicode code points
   localparam logic [15:0] UPPER_HALF_CP [128] = '{
      16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
      16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
      16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
      16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
      16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
      16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
      16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
      16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
      16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
      16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
      16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
      16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
      16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
      16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
      16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
      16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
   };

   typedef struct packed {
      byte_type value;
      logic     last;
   } utf8_byte_type;

   typedef struct packed {
      byte_type   ch;
      logic [1:0] nbytes;
      byte_type   b0;
      byte_type   b1;
      byte_type   b2;
   } char_row_type;

   localparam int unsigned DIRECTED_ROWS = 22;
   localparam char_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{8'h00, NBYTES_ONE,   8'h00, 8'h00, 8'h00},
      '{8'h7F, NBYTES_ONE,   8'h7F, 8'h00, 8'h00},
      '{8'h80, NBYTES_TWO,   8'hC3, 8'h87, 8'h00},
      '{8'hB0, NBYTES_THREE, 8'hE2, 8'h96, 8'h91},
      '{8'hFF, NBYTES_TWO,   8'hC2, 8'hA0, 8'h00},
      '{8'h01, FROM_ENCODER, 8'h00, 8'h00, 8'h00},
      '{8'h20, FROM_ENCODER, 8'h00, 8'h00, 8'h00},
      '{8'h41, FROM_ENCODER, 8'h00, 8'h00, 8'h00},
      '{8'h55, FROM_ENCODER, 8'h00, 8'h00, 8'h00},
      '{8'h7E, FROM_ENCODER, 8'h00, 8'h00, 8'h00},
      '{8'h81, FROM_ENCODER, 8'h00, 8'h00, 8'h00},
      '{8'h9E, FROM_ENCODER, 8'h00, 8'h00, 8'h00},
      '{8'h9F, FROM_ENCODER, 8'h00, 8'h00, 8'h00},
      '{8'hA9, FROM_ENCODER, 8'h00, 8'h00, 8'h00},
      '{8'hAA, FROM_ENCODER, 8'h00, 8'h00, 8'h00},
      '{8'hB3, FROM_ENCODER, 8'h00, 8'h00, 8'h00},
      '{8'hC5, FROM_ENCODER, 8'h00, 8'h00, 8'h00},
      '{8'hDB, FROM_ENCODER, 8'h00, 8'h00, 8'h00},
      '{8'hE0, FROM_ENCODER, 8'h00, 8'h00, 8'h00},
      '{8'hEC, FROM_ENCODER, 8'h00, 8'h00, 8'h00},
      '{8'hF0, FROM_ENCODER, 8'h00, 8'h00, 8'h00},
      '{8'hFE, FROM_ENCODER, 8'h00, 8'h00, 8'h00}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   c437u8_req_if req_if();
   c437u8_rsp_if rsp_if();

   cp437_to_utf8_transcoder_core DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   always #1 clock = ~clock;

   utf8_byte_type utf8_pending_q [$];
   int unsigned mismatches    = 0;
   int unsigned bytes_checked = 0;
   int unsigned chars_sent    = 0;
   int unsigned chars_by_len [1:3] = '{0, 0, 0};
   bit          req_gaps_on   = 1'b1;
   bit          rsp_stalls_on = 1'b1;
   bit          hold_done     = 1'b0;

   task automatic report_mismatch(input string what);
      if (mismatches < MAX_PRINTED)
         $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
   endtask

   // queue the UTF-8 bytes of one character
   task automatic encode_utf8(input byte_type ch);
      logic [15:0] cp;
      if (!ch[7]) begin
         utf8_pending_q.push_back('{ch, 1'b1});
         chars_by_len[1]++;
      end else begin
         cp = UPPER_HALF_CP[ch[6:0]];
         if (cp < 16'h0800) begin
            utf8_pending_q.push_back('{{3'b110, cp[10:6]}, 1'b0});
            utf8_pending_q.push_back('{{2'b10, cp[5:0]}, 1'b1});
            chars_by_len[2]++;
         end else begin
            utf8_pending_q.push_back('{{4'b1110, cp[15:12]}, 1'b0});
            utf8_pending_q.push_back('{{2'b10, cp[11:6]}, 1'b0});
            utf8_pending_q.push_back('{{2'b10, cp[5:0]}, 1'b1});
            chars_by_len[3]++;
         end
      end
   endtask

   // offer one character, hold it until taken, then queue its bytes
   task automatic offer_char(input char_row_type row);
      int unsigned gap;
      gap = req_gaps_on ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.in_byte <= row.ch;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      chars_sent++;
      case (row.nbytes)
         NBYTES_ONE: begin
            utf8_pending_q.push_back('{row.b0, 1'b1});
            chars_by_len[1]++;
         end
         NBYTES_TWO: begin
            utf8_pending_q.push_back('{row.b0, 1'b0});
            utf8_pending_q.push_back('{row.b1, 1'b1});
            chars_by_len[2]++;
         end
         NBYTES_THREE: begin
            utf8_pending_q.push_back('{row.b0, 1'b0});
            utf8_pending_q.push_back('{row.b1, 1'b0});
            utf8_pending_q.push_back('{row.b2, 1'b1});
            chars_by_len[3]++;
         end
         default: encode_utf8(row.ch);
      endcase
      @(negedge clock);
   endtask

   // output side: random stalls, one long hold-off to back up the pipeline
   initial begin : rsp_driver
      int unsigned stall;
      rsp_if.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (!hold_done && bytes_checked >= HOLD_AT_BYTE) begin
            stall     = HOLD_CYCLES;
            hold_done = 1'b1;
         end else begin
            stall = rsp_stalls_on ? $urandom_range(0, 7) : 0;
         end
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : rsp_check
      utf8_byte_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         bytes_checked++;
         if (utf8_pending_q.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %0b",
                                      rsp_if.out_byte, rsp_if.last));
         end else begin
            want = utf8_pending_q.pop_front();
            if (rsp_if.out_byte !== want.value)
               report_mismatch($sformatf("out_byte %02h, expected %02h",
                                         rsp_if.out_byte, want.value));
            if (rsp_if.last !== want.last)
               report_mismatch($sformatf("last %0b on byte %02h, expected %0b",
                                         rsp_if.last, want.value, want.last));
         end
      end
   end

   initial begin : watchdog
      #200000;
      $display("cp437_to_utf8_transcoder_core test failed");
      $finish;
   end

   initial begin : stimulus
      char_row_type row;
      req_if.valid   = 1'b0;
      req_if.in_byte = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++)
         offer_char(DIRECTED[i]);

      // phases: both gaps and stalls, neither, input gaps only, output stalls only
      for (int ph = 0; ph < PHASES; ph++) begin
         req_gaps_on   = (ph == 0) || (ph == 2);
         rsp_stalls_on = (ph == 0) || (ph == 3);
         for (int n = 0; n < RANDOM_CHARS / PHASES; n++) begin
            row = '{default: '0};
            row.nbytes = FROM_ENCODER;
            row.ch = ($urandom_range(0, 2) == 0) ? byte_type'($urandom_range(0, 127))
                                                 : byte_type'($urandom_range(128, 255));
            offer_char(row);
         end
      end
      req_if.valid <= 1'b0;

      while (utf8_pending_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Transcoded %0d characters: %0d single-byte, %0d two-byte, %0d three-byte.",
               chars_sent, chars_by_len[1], chars_by_len[2], chars_by_len[3]);
      $display("Checked %0d UTF-8 bytes with their last flags, %0d mismatches.",
               bytes_checked, mismatches);
      if (mismatches == 0)
         $display("cp437_to_utf8_transcoder_core test passed");
      else
         $display("cp437_to_utf8_transcoder_core test failed");
      $finish;
   end

endmodule
